### src/slsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsd_pkg - shared types and constants of the serial LED strip driver
// Store geometry, bit timing defaults, action and register codes, and the
// structs passed between the store, the frame serialiser and the top level.
// ----------------------------------------------------------------------------
package slsd_pkg;

    localparam int MAX_PIXELS     = 256;
    localparam int ADDR_W         = $clog2(MAX_PIXELS);
    localparam int BITS_PER_PIXEL = 24;
    localparam int BIT_CNT_W      = $clog2(BITS_PER_PIXEL);
    localparam int COLOR_W        = 24;
    localparam int COUNT_W        = 9;
    localparam int TICK_W         = 8;
    localparam int INDEX_W        = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 9;

    localparam logic [COUNT_W-1:0] RST_PIXEL_COUNT = COUNT_W'(0);
    localparam logic [TICK_W-1:0]  RST_ONE_HIGH    = TICK_W'(28);
    localparam logic [TICK_W-1:0]  RST_ONE_LOW     = TICK_W'(10);
    localparam logic [TICK_W-1:0]  RST_ZERO_HIGH   = TICK_W'(9);
    localparam logic [TICK_W-1:0]  RST_ZERO_LOW    = TICK_W'(3);

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_FILL  = 2'd2,
        ACT_START = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_COUNT = 3'd0,
        CFG_ONE_HIGH    = 3'd1,
        CFG_ONE_LOW     = 3'd2,
        CFG_ZERO_HIGH   = 3'd3,
        CFG_ZERO_LOW    = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic [COUNT_W-1:0] pixel_count;
        logic [TICK_W-1:0]  one_high;
        logic [TICK_W-1:0]  one_low;
        logic [TICK_W-1:0]  zero_high;
        logic [TICK_W-1:0]  zero_low;
    } t_timing;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic en;
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] data;
    } t_wr_req;

    typedef struct packed {
        logic refused;
        logic busy;
        logic level;
    } t_result;

    // Pixels in use, clamped to the store depth
    function automatic logic [COUNT_W-1:0] used_pixels(input logic [COUNT_W-1:0] count);
        logic [COUNT_W-1:0] lim;
        lim = COUNT_W'(MAX_PIXELS);
        return (count > lim) ? lim : count;
    endfunction

endpackage

### src/slsd_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsd_store - pixel colour memory
// One write port, one registered read port. Per-entry valid bits, cleared at
// reset, make an unwritten entry read as zero.
// ----------------------------------------------------------------------------
module slsd_store (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  slsd_pkg::t_wr_req            i_wr,
    input  slsd_pkg::t_rd_req            i_rd,
    output logic [slsd_pkg::COLOR_W-1:0] o_rd_data
);

    logic [slsd_pkg::COLOR_W-1:0] r_mem [slsd_pkg::MAX_PIXELS];
    logic [slsd_pkg::MAX_PIXELS-1:0] r_valid;
    logic [slsd_pkg::COLOR_W-1:0] r_rd_data;
    logic                         r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rd_ok <= r_valid[i_rd.addr];
            end
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

### src/slsd_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsd_frame - frame serialiser
// Shifts pixels out MSB first, one tick per accepted item, timing each bit as
// a high phase then a low phase. The colour of the next pixel is prefetched
// from the store while the current one is sent.
// ----------------------------------------------------------------------------
module slsd_frame (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  slsd_pkg::t_action            i_action,
    input  slsd_pkg::t_timing            i_timing,
    input  logic [slsd_pkg::COLOR_W-1:0] i_first,
    input  logic [slsd_pkg::COLOR_W-1:0] i_rd_data,
    output slsd_pkg::t_rd_req            o_rd,
    output slsd_pkg::t_result            o_result,
    output logic                         o_sending
);

    typedef struct packed {
        logic                           sending;
        logic [slsd_pkg::COUNT_W-1:0]   pc;
        logic [slsd_pkg::BIT_CNT_W-1:0] bitc;
        logic                           low;
        logic [slsd_pkg::TICK_W-1:0]    ph;
        logic [slsd_pkg::COLOR_W-1:0]   sw;
    } t_fstate;

    t_fstate r_state;
    t_fstate n_state;
    t_fstate st;
    t_fstate nx;

    logic [slsd_pkg::COUNT_W-1:0] used;
    logic [slsd_pkg::TICK_W-1:0]  ph_dec;
    logic [slsd_pkg::COUNT_W-1:0] pc_inc;
    logic                         start;
    logic                         tick;
    logic                         level;
    logic                         adv_rd;

    function automatic logic [slsd_pkg::TICK_W-1:0] at_least_one(
        input logic [slsd_pkg::TICK_W-1:0] v);
        return (v == '0) ? slsd_pkg::TICK_W'(1) : v;
    endfunction

    function automatic logic [slsd_pkg::TICK_W-1:0] high_time(
        input logic [slsd_pkg::COLOR_W-1:0] w, input slsd_pkg::t_timing t);
        return at_least_one(w[slsd_pkg::COLOR_W-1] ? t.one_high : t.zero_high);
    endfunction

    function automatic logic [slsd_pkg::TICK_W-1:0] low_time(
        input logic [slsd_pkg::COLOR_W-1:0] w, input slsd_pkg::t_timing t);
        return at_least_one(w[slsd_pkg::COLOR_W-1] ? t.one_low : t.zero_low);
    endfunction

    assign used  = slsd_pkg::used_pixels(i_timing.pixel_count);
    assign start = i_en && !r_state.sending && (i_action == slsd_pkg::ACT_START)
                   && (used != '0);
    assign tick  = i_en && (r_state.sending || start);

    always_comb begin
        st = r_state;
        if (start) begin
            st.sending = 1'b1;
            st.pc      = '0;
            st.bitc    = '0;
            st.low     = 1'b0;
            st.sw      = i_first;
            st.ph      = high_time(i_first, i_timing);
        end

        nx     = st;
        level  = !st.low;
        adv_rd = 1'b0;
        ph_dec = st.ph - {{(slsd_pkg::TICK_W-1){1'b0}}, (st.ph != '0)};
        pc_inc = st.pc + slsd_pkg::COUNT_W'(1);

        if (ph_dec != '0) begin
            nx.ph = ph_dec;
        end else if (!st.low) begin
            nx.low = 1'b1;
            nx.ph  = low_time(st.sw, i_timing);
        end else begin
            nx.low = 1'b0;
            nx.sw  = {st.sw[slsd_pkg::COLOR_W-2:0], 1'b0};
            if (st.bitc == slsd_pkg::BIT_CNT_W'(slsd_pkg::BITS_PER_PIXEL - 1)) begin
                nx.bitc = '0;
                nx.pc   = pc_inc;
                if (pc_inc >= used) begin
                    nx.sending = 1'b0;
                    nx.sw      = '0;
                end else begin
                    // take the prefetched pixel, fetch the one after
                    nx.sw  = i_rd_data;
                    adv_rd = 1'b1;
                end
            end else begin
                nx.bitc = st.bitc + slsd_pkg::BIT_CNT_W'(1);
            end
            nx.ph = nx.sending ? high_time(nx.sw, i_timing) : '0;
        end

        n_state = tick ? nx : r_state;
    end

    always_comb begin
        o_rd.en   = start || (tick && adv_rd);
        o_rd.addr = start ? slsd_pkg::ADDR_W'(1)
                          : pc_inc[slsd_pkg::ADDR_W-1:0] + slsd_pkg::ADDR_W'(1);
    end

    assign o_result.level   = tick ? level : 1'b0;
    assign o_result.busy    = n_state.sending;
    assign o_result.refused = r_state.sending && (i_action != slsd_pkg::ACT_TICK);
    assign o_sending        = r_state.sending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_phase_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.sending |-> (r_state.ph != '0))
        else $error("phase counter empty during a frame");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.sending |-> (r_state.bitc == '0 && !r_state.low && r_state.ph == '0))
        else $error("serialiser state left over after a frame");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bitc < slsd_pkg::BIT_CNT_W'(slsd_pkg::BITS_PER_PIXEL))
        else $error("bit counter beyond pixel width");
`endif

endmodule

### src/serial_led_strip_driver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_led_strip_driver - serial LED strip driver
// Pixel colour store with write, fill and frame start actions, and a frame
// serialiser that drives the strip data line one tick per item.
// ----------------------------------------------------------------------------
// Channel    | Direction | Handshake                 | Content
// s_axis     | in        | tvalid / tready           | action, pixel index, colour
// m_axis     | out       | tvalid / tready           | line level, busy, refused
// cfg        | in        | valid / ready (always on) | register index, write data
//
// Item results leave through a
// single output register, so an item is taken while the previous result is
// being taken. A fill holds s_axis off while the fill sweep writes each
// pixel in use through the store port. Reset clears every pixel at once.
// ----------------------------------------------------------------------------
module serial_led_strip_driver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [7:0] pixel_index, [31:8] color
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] action
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [0] line_level, [1] busy_res, [2] refused
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [slsd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [slsd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    slsd_pkg::t_timing r_timing;
    slsd_pkg::t_action action;
    slsd_pkg::t_wr_req wr;
    slsd_pkg::t_rd_req rd;
    slsd_pkg::t_result result;

    logic [slsd_pkg::INDEX_W-1:0] pixel_index;
    logic [slsd_pkg::COLOR_W-1:0] color;
    logic [slsd_pkg::COLOR_W-1:0] rd_data;
    logic [slsd_pkg::COUNT_W-1:0] used;
    logic                         accept;
    logic                         sending;
    logic                         act_write;
    logic                         act_fill;

    logic                         r_fill_busy;
    logic [slsd_pkg::COUNT_W-1:0] r_fill_addr;
    logic [slsd_pkg::COUNT_W-1:0] r_fill_end;
    logic [slsd_pkg::COLOR_W-1:0] r_fill_color;
    logic [slsd_pkg::COLOR_W-1:0] r_pix0;
    logic                         r_out_valid;
    slsd_pkg::t_result            r_out;

    assign action      = slsd_pkg::t_action'(i_s_axis_tuser);
    assign pixel_index = i_s_axis_tdata[slsd_pkg::INDEX_W-1:0];
    assign color       = i_s_axis_tdata[slsd_pkg::INDEX_W +: slsd_pkg::COLOR_W];
    assign used        = slsd_pkg::used_pixels(r_timing.pixel_count);

    assign o_s_axis_tready = !r_fill_busy && (!r_out_valid || i_m_axis_tready);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign act_write       = accept && !sending && (action == slsd_pkg::ACT_WRITE)
                             && ({1'b0, pixel_index} < slsd_pkg::COUNT_W'(slsd_pkg::MAX_PIXELS));
    assign act_fill        = accept && !sending && (action == slsd_pkg::ACT_FILL)
                             && (used != '0);

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.pixel_count <= slsd_pkg::RST_PIXEL_COUNT;
            r_timing.one_high    <= slsd_pkg::RST_ONE_HIGH;
            r_timing.one_low     <= slsd_pkg::RST_ONE_LOW;
            r_timing.zero_high   <= slsd_pkg::RST_ZERO_HIGH;
            r_timing.zero_low    <= slsd_pkg::RST_ZERO_LOW;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (slsd_pkg::t_cfg_reg'(i_cfg_index))
                slsd_pkg::CFG_PIXEL_COUNT: r_timing.pixel_count <= i_cfg_data;
                slsd_pkg::CFG_ONE_HIGH:    r_timing.one_high  <= i_cfg_data[slsd_pkg::TICK_W-1:0];
                slsd_pkg::CFG_ONE_LOW:     r_timing.one_low   <= i_cfg_data[slsd_pkg::TICK_W-1:0];
                slsd_pkg::CFG_ZERO_HIGH:   r_timing.zero_high <= i_cfg_data[slsd_pkg::TICK_W-1:0];
                slsd_pkg::CFG_ZERO_LOW:    r_timing.zero_low  <= i_cfg_data[slsd_pkg::TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // fill sweep and shadow copy of pixel 0 for a frame start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_busy <= 1'b0;
            r_fill_addr <= '0;
            r_pix0      <= '0;
        end else begin
            if (act_fill) begin
                r_fill_busy <= 1'b1;
                r_fill_addr <= '0;
                r_pix0      <= color;
            end else if (r_fill_busy) begin
                r_fill_addr <= r_fill_addr + slsd_pkg::COUNT_W'(1);
                if (r_fill_addr + slsd_pkg::COUNT_W'(1) == r_fill_end) begin
                    r_fill_busy <= 1'b0;
                end
            end
            if (act_write && pixel_index == '0) begin
                r_pix0 <= color;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (act_fill) begin
            r_fill_end   <= used;
            r_fill_color <= color;
        end
    end

    always_comb begin
        if (r_fill_busy) begin
            wr.en   = 1'b1;
            wr.addr = r_fill_addr[slsd_pkg::ADDR_W-1:0];
            wr.data = r_fill_color;
        end else begin
            wr.en   = act_write;
            wr.addr = pixel_index[slsd_pkg::ADDR_W-1:0];
            wr.data = color;
        end
    end

    slsd_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_rd      (rd),
        .o_rd_data (rd_data)
    );

    slsd_frame u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (accept),
        .i_action  (action),
        .i_timing  (r_timing),
        .i_first   (r_pix0),
        .i_rd_data (rd_data),
        .o_rd      (rd),
        .o_result  (result),
        .o_sending (sending)
    );

    // output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_out.refused, r_out.busy, r_out.level};

`ifndef SYNTHESIS
    a_fill_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill_busy |-> (!o_s_axis_tready && !sending))
        else $error("item taken or frame running during a fill");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill_busy |-> (r_fill_addr < r_fill_end))
        else $error("fill sweep beyond pixel count");

    a_no_write_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sending |-> !wr.en)
        else $error("store written while a frame is sent");
`endif

endmodule
